// ----- hdl/pmq_pkg.sv -----
// shared types, constants and helpers of the priority message queue
package pmq_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int PRIORITY_BITS = 8;
  localparam int AW            = $clog2(QUEUE_DEPTH);
  localparam int CW            = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CMD_PRIO    = 3'd0;
  localparam logic [2:0] CMD_HEAD    = 3'd1;
  localparam logic [2:0] CMD_TAIL    = 3'd2;
  localparam logic [2:0] CMD_POP     = 3'd3;
  localparam logic [2:0] CMD_PEEK    = 3'd4;
  localparam logic [2:0] CMD_DEACT   = 3'd5;
  localparam logic [2:0] CMD_ACT     = 3'd6;
  localparam logic [2:0] CMD_FLUSH   = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHUT  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [15:0]              handle;
    logic [15:0]              bytes;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [22:0] byte_total;
    logic [15:0] out_handle;
    logic [15:0] out_bytes;
    logic [7:0]  out_priority;
    logic        prev_active;
  } result_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          idle;
  } mon_t;

  // physical slot of a logical position counted from the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [AW:0] s;
    s = (AW+1)'(hd) + (AW+1)'(l);
    if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

// ----- hdl/pmq_ifs.sv -----
// channel interfaces of the priority message queue

interface pmq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] item_handle;
  logic [15:0] item_bytes;
  logic [7:0]  item_priority;
  modport source(output valid, command, item_handle, item_bytes, item_priority, input ready);
  modport sink(input valid, command, item_handle, item_bytes, item_priority, output ready);
endinterface

interface pmq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic [22:0] byte_total;
  logic [15:0] out_handle;
  logic [15:0] out_bytes;
  logic [7:0]  out_priority;
  logic        prev_active;
  modport source(output valid, status, entry_count, byte_total, out_handle, out_bytes,
                 out_priority, prev_active, input ready);
  modport sink(input valid, status, entry_count, byte_total, out_handle, out_bytes,
               out_priority, prev_active, output ready);
endinterface

interface pmq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hdl/pmq_store.sv -----
// slot memory: one write port, one registered read port
module pmq_store (
  input  logic                 clk,
  input  logic                 we,
  input  logic [pmq_pkg::AW-1:0] waddr,
  input  pmq_pkg::entry_t      wdata,
  input  logic [pmq_pkg::AW-1:0] raddr,
  output pmq_pkg::entry_t      rdata
);

  pmq_pkg::entry_t mem [pmq_pkg::QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pmq_ctrl.sv -----
// command sequencer: head pointer, counts, flags and the insert scan
module pmq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  pmq_cmd_if.sink                cmd,
  pmq_res_if.source              res,
  pmq_cfg_if.sink                cfg,
  output logic                   we,
  output logic [pmq_pkg::AW-1:0] waddr,
  output pmq_pkg::entry_t        wdata,
  output logic [pmq_pkg::AW-1:0] raddr,
  input  pmq_pkg::entry_t        rdata,
  output pmq_pkg::mon_t          mon
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]              state, state_next;
  logic [pmq_pkg::AW-1:0]  hd, hd_next;
  logic [pmq_pkg::CW-1:0]  cnt, cnt_next;
  logic [pmq_pkg::CW-1:0]  pos, pos_next;
  logic [22:0]             tot, tot_next;
  logic                    inact, inact_next;
  logic                    popc, popc_next;
  logic [31:0]             hwm;
  pmq_pkg::entry_t         newe, newe_next;
  pmq_pkg::result_t        pend, pend_next;
  pmq_pkg::result_t        outr;
  logic                    ov;
  logic                    accept;
  logic                    load;
  pmq_pkg::entry_t         in_e;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign load      = (state == S_FIN) && (!ov || res.ready);
  assign cfg.ready = 1'b1;
  assign in_e      = '{handle: cmd.item_handle, bytes: cmd.item_bytes,
                       prio: cmd.item_priority[pmq_pkg::PRIORITY_BITS-1:0]};
  assign mon.count = cnt;
  assign mon.idle  = (state == S_IDLE);

  // sequencer and memory control
  always_comb begin
    logic [pmq_pkg::CW-1:0] c1;
    logic [22:0]            t1;
    logic [pmq_pkg::AW-1:0] hm1;
    c1         = cnt + pmq_pkg::CW'(1);
    t1         = tot + 23'(newe.bytes);
    hm1        = (hd == '0) ? pmq_pkg::AW'(pmq_pkg::QUEUE_DEPTH - 1) : hd - pmq_pkg::AW'(1);
    state_next = state;
    hd_next    = hd;
    cnt_next   = cnt;
    pos_next   = pos;
    tot_next   = tot;
    inact_next = inact;
    popc_next  = popc;
    newe_next  = newe;
    pend_next  = pend;
    we         = 1'b0;
    waddr      = hd;
    wdata      = newe;
    raddr      = hd;
    case (state)
      S_IDLE: begin
        if (accept) begin
          pend_next = '{status: pmq_pkg::ST_OK, entry_count: 7'(cnt), byte_total: tot,
                        out_handle: '0, out_bytes: '0, out_priority: '0, prev_active: 1'b0};
          newe_next = in_e;
          state_next = S_FIN;
          if (cmd.command <= pmq_pkg::CMD_TAIL) begin
            if (inact) begin
              pend_next.status = pmq_pkg::ST_SHUT;
            end else if ({9'd0, tot} > hwm || cnt >= pmq_pkg::CW'(pmq_pkg::QUEUE_DEPTH)) begin
              pend_next.status = pmq_pkg::ST_FULL;
            end else if (cmd.command == pmq_pkg::CMD_PRIO && cnt != '0) begin
              // scan back from the tail
              raddr      = pmq_pkg::phys(hd, cnt - pmq_pkg::CW'(1));
              pos_next   = cnt;
              state_next = S_SCAN;
            end else begin
              we    = 1'b1;
              wdata = in_e;
              if (cmd.command == pmq_pkg::CMD_HEAD) begin
                waddr   = hm1;
                hd_next = hm1;
              end else begin
                waddr = pmq_pkg::phys(hd, cnt);
              end
              cnt_next = c1;
              tot_next = tot + 23'(cmd.item_bytes);
              pend_next.entry_count = 7'(c1);
              pend_next.byte_total  = tot + 23'(cmd.item_bytes);
            end
          end else if (cmd.command == pmq_pkg::CMD_POP || cmd.command == pmq_pkg::CMD_PEEK) begin
            if (inact) begin
              pend_next.status = pmq_pkg::ST_SHUT;
            end else if (cnt == '0) begin
              pend_next.status = pmq_pkg::ST_EMPTY;
            end else begin
              raddr      = hd;
              popc_next  = (cmd.command == pmq_pkg::CMD_POP);
              state_next = S_HEAD;
            end
          end else begin
            pend_next.prev_active = !inact;
            inact_next = (cmd.command != pmq_pkg::CMD_ACT);
            if (cmd.command == pmq_pkg::CMD_FLUSH) begin
              cnt_next = '0;
              tot_next = '0;
              pend_next.entry_count = '0;
              pend_next.byte_total  = '0;
            end
          end
        end
      end
      S_HEAD: begin
        pend_next.out_handle   = rdata.handle;
        pend_next.out_bytes    = rdata.bytes;
        pend_next.out_priority = 8'(rdata.prio);
        if (popc) begin
          hd_next  = pmq_pkg::phys(hd, pmq_pkg::CW'(1));
          cnt_next = cnt - pmq_pkg::CW'(1);
          tot_next = tot - 23'(rdata.bytes);
          pend_next.entry_count = 7'(cnt - pmq_pkg::CW'(1));
          pend_next.byte_total  = tot - 23'(rdata.bytes);
        end
        state_next = S_FIN;
      end
      S_SCAN: begin
        we    = 1'b1;
        waddr = pmq_pkg::phys(hd, pos);
        if (rdata.prio < newe.prio) begin
          // move the lower entry up one slot
          wdata    = rdata;
          pos_next = pos - pmq_pkg::CW'(1);
          if (pos == pmq_pkg::CW'(1)) begin
            state_next = S_PUT;
          end else begin
            raddr = pmq_pkg::phys(hd, pos - pmq_pkg::CW'(2));
          end
        end else begin
          wdata      = newe;
          cnt_next   = c1;
          tot_next   = t1;
          pend_next.entry_count = 7'(c1);
          pend_next.byte_total  = t1;
          state_next = S_FIN;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = pmq_pkg::phys(hd, pos);
        wdata      = newe;
        cnt_next   = c1;
        tot_next   = t1;
        pend_next.entry_count = 7'(c1);
        pend_next.byte_total  = t1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hd    <= '0;
      cnt   <= '0;
      tot   <= '0;
      inact <= 1'b0;
      hwm   <= 32'd16384;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      hd    <= hd_next;
      cnt   <= cnt_next;
      tot   <= tot_next;
      inact <= inact_next;
      if (cfg.valid) hwm <= cfg.data;
      if (load) ov <= 1'b1;
      else if (res.ready) ov <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    popc <= popc_next;
    newe <= newe_next;
    pend <= pend_next;
    if (load) outr <= pend;
  end

  // result beat
  assign res.valid        = ov;
  assign res.status       = outr.status;
  assign res.entry_count  = outr.entry_count;
  assign res.byte_total   = outr.byte_total;
  assign res.out_handle   = outr.out_handle;
  assign res.out_bytes    = outr.out_bytes;
  assign res.out_priority = outr.out_priority;
  assign res.prev_active  = outr.prev_active;

endmodule

// ----- hdl/priority_message_queue.sv -----
// top level of the priority message queue
//
// channel | dir | beat
// cmd     | in  | command, item_handle, item_bytes, item_priority
// res     | out | status, entry_count, byte_total, out_handle, out_bytes, out_priority,
//         |     | prev_active
// cfg     | in  | high water mark write, always ready
//
// push, flag and refused commands and an insert into an empty queue go straight from
// idle to the finish state; pop and peek first read the head slot
// a prioritized insert into a nonempty queue moves the entries of lower priority up,
// one per cycle through the slot memory's read and write ports
// synchronous reset clears counts and flags; slot contents stay undefined
// a held result beat parks in the output register and the sequencer waits
module priority_message_queue (
  input  logic      clk,
  input  logic      rst,
  pmq_cmd_if.sink   cmd,
  pmq_res_if.source res,
  pmq_cfg_if.sink   cfg
);

  logic                   we;
  logic [pmq_pkg::AW-1:0] waddr;
  logic [pmq_pkg::AW-1:0] raddr;
  pmq_pkg::entry_t        wdata;
  pmq_pkg::entry_t        rdata;
  pmq_pkg::mon_t          mon;

  // sequencer
  pmq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res), .cfg(cfg),
    .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata), .mon(mon)
  );

  // slot memory
  pmq_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // count stays within the slots
  a_count: assert property (@(posedge clk) disable iff (rst)
    mon.count <= pmq_pkg::CW'(pmq_pkg::QUEUE_DEPTH))
    else $error("entry count above depth");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command taken while busy");

  // reset empties the queue
  a_reset: assert property (@(posedge clk) rst |=> (mon.count == '0 && mon.idle))
    else $error("queue not empty after reset");

endmodule

// ----- test/tb_priority_message_queue.sv -----
// testbench of the priority message queue: random and directed commands checked beat by beat
module tb_priority_message_queue;

  typedef struct {
    logic [2:0]  command;
    logic [15:0] handle;
    logic [15:0] bytes;
    logic [7:0]  prio;
  } cmd_beat_t;

  logic clk;
  logic rst;

  pmq_cmd_if cmd ();
  pmq_res_if res ();
  pmq_cfg_if cfg ();

  priority_message_queue u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg)
  );

  // shadow of the queue contents and flags
  pmq_pkg::entry_t shadow_slots[$];
  logic [22:0]     shadow_bytes;
  logic            shadow_inactive;
  logic [31:0]     shadow_hwm;

  cmd_beat_t        pending_cmds[$];
  pmq_pkg::result_t expected_results[$];

  int  n_queued;
  int  n_taken;
  int  n_results;
  int  n_errors;
  int  n_full;
  int  n_shut;
  int  n_empty;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  quiet;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0h expected %0h", n_results, field, got, want);
    n_errors++;
  endtask

  // work out the result of one command and update the shadow state
  function automatic pmq_pkg::result_t apply_command(input cmd_beat_t c);
    pmq_pkg::result_t r;
    pmq_pkg::entry_t  e;
    int               pos;
    r = '0;
    e.handle = c.handle;
    e.bytes  = c.bytes;
    e.prio   = c.prio;
    case (c.command)
      pmq_pkg::CMD_PRIO, pmq_pkg::CMD_HEAD, pmq_pkg::CMD_TAIL: begin
        if (shadow_inactive) begin
          r.status = pmq_pkg::ST_SHUT;
        end else if ({9'd0, shadow_bytes} > shadow_hwm ||
                     shadow_slots.size() >= pmq_pkg::QUEUE_DEPTH) begin
          r.status = pmq_pkg::ST_FULL;
        end else begin
          if (c.command == pmq_pkg::CMD_HEAD) begin
            pos = 0;
          end else begin
            pos = shadow_slots.size();
            if (c.command == pmq_pkg::CMD_PRIO) begin
              while (pos > 0 && shadow_slots[pos-1].prio < c.prio) pos--;
            end
          end
          shadow_slots.insert(pos, e);
          shadow_bytes = shadow_bytes + c.bytes;
        end
      end
      pmq_pkg::CMD_POP, pmq_pkg::CMD_PEEK: begin
        if (shadow_inactive) begin
          r.status = pmq_pkg::ST_SHUT;
        end else if (shadow_slots.size() == 0) begin
          r.status = pmq_pkg::ST_EMPTY;
        end else begin
          r.out_handle   = shadow_slots[0].handle;
          r.out_bytes    = shadow_slots[0].bytes;
          r.out_priority = shadow_slots[0].prio;
          if (c.command == pmq_pkg::CMD_POP) begin
            shadow_bytes = shadow_bytes - shadow_slots[0].bytes;
            void'(shadow_slots.pop_front());
          end
        end
      end
      default: begin
        r.prev_active = !shadow_inactive;
        if (c.command == pmq_pkg::CMD_ACT) begin
          shadow_inactive = 1'b0;
        end else begin
          shadow_inactive = 1'b1;
          if (c.command == pmq_pkg::CMD_FLUSH) begin
            shadow_slots.delete();
            shadow_bytes = '0;
          end
        end
      end
    endcase
    r.entry_count = 7'(shadow_slots.size());
    r.byte_total  = shadow_bytes;
    return r;
  endfunction

  // command driver with idle bursts
  always @(posedge clk) begin
    cmd_beat_t c;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!(cmd.valid && !cmd.ready)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        cmd.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        send_gap <= $urandom_range(0, 17);
        cmd.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        cmd.valid         <= 1'b1;
        cmd.command       <= c.command;
        cmd.item_handle   <= c.handle;
        cmd.item_bytes    <= c.bytes;
        cmd.item_priority <= c.prio;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // result ready with idle bursts and long holds
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      res.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 17);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin
    cmd_beat_t        c;
    pmq_pkg::result_t want;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        c.command = cmd.command;
        c.handle  = cmd.item_handle;
        c.bytes   = cmd.item_bytes;
        c.prio    = cmd.item_priority;
        want = apply_command(c);
        if (want.status == pmq_pkg::ST_FULL) n_full++;
        if (want.status == pmq_pkg::ST_SHUT) n_shut++;
        if (want.status == pmq_pkg::ST_EMPTY) n_empty++;
        expected_results.push_back(want);
        n_taken++;
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (res.status !== want.status) report_mismatch("status", res.status, want.status);
          if (res.entry_count !== want.entry_count)
            report_mismatch("entry_count", res.entry_count, want.entry_count);
          if (res.byte_total !== want.byte_total)
            report_mismatch("byte_total", res.byte_total, want.byte_total);
          if (res.out_handle !== want.out_handle)
            report_mismatch("out_handle", res.out_handle, want.out_handle);
          if (res.out_bytes !== want.out_bytes)
            report_mismatch("out_bytes", res.out_bytes, want.out_bytes);
          if (res.out_priority !== want.out_priority)
            report_mismatch("out_priority", res.out_priority, want.out_priority);
          if (res.prev_active !== want.prev_active)
            report_mismatch("prev_active", res.prev_active, want.prev_active);
        end
        n_results++;
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [15:0] h, input logic [15:0] b,
                         input logic [7:0] p);
    cmd_beat_t c;
    c.command = op;
    c.handle  = h;
    c.bytes   = b;
    c.prio    = p;
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  // wait until every command is taken and every result has come
  task automatic wait_drained();
    while (n_taken != n_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  // high water mark write once every command has been answered
  task automatic write_hwm(input logic [31:0] value);
    wait_drained();
    repeat (80) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid  <= 1'b0;
    shadow_hwm = value;
  endtask

  // random commands; fill_bias steers toward inserts or removals
  task automatic add_random(input int count, input int fill_bias, input bit small_bytes);
    int          w;
    logic [2:0]  op;
    logic [15:0] b;
    logic [7:0]  p;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < fill_bias) op = logic'($urandom_range(0, 99) < 60) ? pmq_pkg::CMD_PRIO :
                              ($urandom_range(0, 1) ? pmq_pkg::CMD_HEAD : pmq_pkg::CMD_TAIL);
      else if (w < 88) op = ($urandom_range(0, 3) == 0) ? pmq_pkg::CMD_PEEK : pmq_pkg::CMD_POP;
      else if (w < 95) op = pmq_pkg::CMD_ACT;
      else if (w < 98) op = pmq_pkg::CMD_DEACT;
      else op = pmq_pkg::CMD_FLUSH;
      b = small_bytes ? 16'($urandom_range(0, 300)) : 16'($urandom);
      p = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      add_cmd(op, 16'($urandom), b, p);
    end
  endtask

  // run limit
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    n_queued = 0; n_taken = 0; n_results = 0; n_errors = 0;
    n_full = 0; n_shut = 0; n_empty = 0;
    send_gap = 0; recv_gap = 0; hold_left = 0; quiet = 0;
    shadow_bytes = '0; shadow_inactive = 1'b0; shadow_hwm = 32'd16384;
    cmd.valid = 1'b0; cmd.command = pmq_pkg::CMD_PEEK;
    cmd.item_handle = '0; cmd.item_bytes = '0; cmd.item_priority = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.data = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty refusals, extremes, ties, shut down, flags, full by bytes
    add_cmd(pmq_pkg::CMD_POP, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_PRIO, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_PRIO, 16'hffff, 16'h0100, 8'hff);
    add_cmd(pmq_pkg::CMD_PRIO, 16'h1111, 16'h0010, 8'h05);
    add_cmd(pmq_pkg::CMD_PRIO, 16'h2222, 16'h0020, 8'h05);
    add_cmd(pmq_pkg::CMD_HEAD, 16'h3333, 16'h0001, 8'h00);
    add_cmd(pmq_pkg::CMD_TAIL, 16'h4444, 16'h0002, 8'hff);
    add_cmd(pmq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_POP, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_DEACT, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_DEACT, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_PRIO, 16'h5555, 16'h0005, 8'h01);
    add_cmd(pmq_pkg::CMD_POP, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_TAIL, 16'hffff, 16'hffff, 8'hff);
    add_cmd(pmq_pkg::CMD_HEAD, 16'h6666, 16'h0001, 8'h00);
    add_cmd(pmq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_FLUSH, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_FLUSH, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    add_cmd(pmq_pkg::CMD_POP, 16'h0000, 16'h0000, 8'h00);

    // default mark, mixed traffic
    for (int k = 0; k < 4; k++) add_random(50, (k % 2) ? 30 : 70, k < 2);

    // no byte limit: fill every slot, with results held back at first
    write_hwm(32'hffff_ffff);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    @(posedge clk);
    hold_left <= 400;
    for (int i = 0; i < 70; i++)
      add_cmd(pmq_pkg::CMD_PRIO, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 7)));
    for (int i = 0; i < 70; i++) add_cmd(pmq_pkg::CMD_POP, 16'h0000, 16'h0000, 8'h00);
    for (int k = 0; k < 6; k++) add_random(50, (k % 2) ? 35 : 85, 1'b0);

    // zero mark: inserts get in only while the byte total is zero
    write_hwm(32'h0000_0000);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    for (int k = 0; k < 4; k++) add_random(50, (k % 2) ? 30 : 75, 1'b1);

    // sender pause until the block has answered everything
    wait_drained();
    repeat (10) @(posedge clk);
    add_random(50, 60, 1'b1);

    // low, random and raised marks
    write_hwm(32'd1000);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    for (int k = 0; k < 4; k++) add_random(50, (k % 2) ? 30 : 75, 1'b1);
    write_hwm($urandom);
    for (int k = 0; k < 6; k++) add_random(50, (k % 2) ? 35 : 80, $urandom_range(0, 1));
    write_hwm(32'd20000);
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    for (int k = 0; k < 4; k++) add_random(50, (k % 2) ? 30 : 80, 1'b1);

    // last stretch without idling
    write_hwm(32'd16384);
    quiet = 1;
    add_cmd(pmq_pkg::CMD_ACT, 16'h0000, 16'h0000, 8'h00);
    for (int k = 0; k < 3; k++) add_random(50, (k % 2) ? 30 : 80, 1'b1);

    wait_drained();
    repeat (80) @(posedge clk);
    $display("commands %0d, results %0d, refusals: full %0d shut %0d empty %0d",
             n_taken, n_results, n_full, n_shut, n_empty);
    $display("high water marks covered: 0, 1000, 16384, 20000, random, all ones");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pmq_pkg.sv
hdl/pmq_ifs.sv
hdl/pmq_store.sv
hdl/pmq_ctrl.sv
hdl/priority_message_queue.sv
test/tb_priority_message_queue.sv
